// ===== hdl/mbrpt_pkg.sv =====
// Shared types, constants and helpers for the boot-sector partition table parser.
// No dependencies; the capture, sequencer and top-level files import this package.

package mbrpt_pkg;

  localparam int IDX_W     = 9;
  localparam int STORE_AW  = 6;

  localparam logic [IDX_W-1:0] LAST_IDX  = 9'h1FF;
  localparam logic [IDX_W-1:0] TBL_OFS   = 9'h1BE;
  localparam logic [IDX_W-1:0] SIG_OFS   = 9'h1FE;
  localparam logic [IDX_W-1:0] FAT_OFS   = 9'h036;
  localparam logic [IDX_W-1:0] FAT32_OFS = 9'h052;
  localparam logic [IDX_W-1:0] FAT_LEN   = 9'd3;
  localparam logic [IDX_W-1:0] FAT32_LEN = 9'd5;

  localparam logic [7:0] SIG_LOW  = 8'h55;
  localparam logic [7:0] SIG_HIGH = 8'hAA;
  localparam logic [7:0] EXT_CHS  = 8'h05;
  localparam logic [7:0] EXT_LBA  = 8'h0F;
  localparam logic [7:0] EXT_ALT  = 8'h85;
  localparam logic [7:0] NUM_MAX  = 8'hFF;

  // Byte offsets inside one 16-byte table entry
  localparam logic [3:0] TYPE_OFS  = 4'd4;
  localparam logic [3:0] START_OFS = 4'd8;
  localparam logic [3:0] START_END = 4'd11;
  localparam logic [3:0] LEN_END   = 4'd15;

  typedef enum logic [2:0] {
    KIND_PART  = 3'd0,
    KIND_LINK  = 3'd1,
    KIND_OK    = 3'd2,
    KIND_NOSIG = 3'd3,
    KIND_BOOT  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_DRAIN,
    S_EVAL,
    S_STATUS
  } seq_state_t;

  // Sector summary handed from the byte capture to the sequencer
  typedef struct packed {
    logic        done;
    logic        sig_ok;
    logic        boot_rec;
    logic [31:0] sector_lba;
    logic [31:0] ext_base;
    logic [7:0]  first_num;
  } sector_info_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  part_number;
    logic [31:0] start_lba;
    logic [31:0] length;
    logic [7:0]  sys_ind;
    logic [31:0] child_base;
    logic        last;
  } result_t;

  // ASCII "FAT32"
  function automatic logic [7:0] fat_char(input logic [2:0] k);
    logic [7:0] c;
    unique case (k)
      3'd0:    c = 8'h46;
      3'd1:    c = 8'h41;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h33;
      3'd4:    c = 8'h32;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_ext_type(input logic [7:0] t);
    return (t == EXT_CHS) || (t == EXT_LBA) || (t == EXT_ALT);
  endfunction

endpackage

// ===== hdl/mbrpt_if.sv =====
// Valid/ready channel interfaces: sector bytes in, parse results out.
// Field widths follow the result_t and input field definitions of mbrpt_pkg.

interface mbrpt_sector_if;
  logic        valid;
  logic        ready;
  logic [7:0]  sector_byte;
  logic [31:0] sector_lba;
  logic [31:0] ext_base;
  logic [7:0]  first_part_num;

  modport source (output valid, sector_byte, sector_lba, ext_base, first_part_num,
                  input ready);
  modport sink   (input valid, sector_byte, sector_lba, ext_base, first_part_num,
                  output ready);
endinterface

interface mbrpt_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  part_number;
  logic [31:0] start_lba;
  logic [31:0] length;
  logic [7:0]  sys_ind;
  logic [31:0] child_base;
  logic        last;

  modport source (output valid, kind, part_number, start_lba, length, sys_ind,
                  child_base, last, input ready);
  modport sink   (input valid, kind, part_number, start_lba, length, sys_ind,
                  child_base, last, output ready);
endinterface

// ===== hdl/mbrpt_capture.sv =====
// Byte capture: offset counter, FAT text match, signature, held sector values
// and the 64-byte partition table store. Depends on mbrpt_pkg.

module mbrpt_capture
  import mbrpt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          byte_in,
  input  logic [31:0]         lba_in,
  input  logic [31:0]         base_in,
  input  logic [7:0]          num_in,
  input  logic [STORE_AW-1:0] rd_addr,
  output logic [7:0]          rd_data,
  output sector_info_t        info
);

  logic [IDX_W-1:0] byte_index;
  logic             fat_match;
  logic             fat32_match;
  logic [7:0]       sig_low_byte;
  logic [31:0]      held_sector_lba;
  logic [31:0]      held_ext_base;
  logic [7:0]       held_first_num;

  logic [7:0]       table_store [2**STORE_AW];

  logic [2:0]          rel_fat;
  logic [2:0]          rel_fat32;
  logic [STORE_AW-1:0] rel_tbl;
  logic             in_fat;
  logic             in_fat32;
  logic             in_tbl;
  logic             m_fat;
  logic             m_fat32;

  assign rel_fat   = 3'(byte_index - FAT_OFS);
  assign rel_fat32 = 3'(byte_index - FAT32_OFS);
  assign rel_tbl   = STORE_AW'(byte_index - TBL_OFS);
  assign in_fat    = (byte_index >= FAT_OFS) && (byte_index < FAT_OFS + FAT_LEN);
  assign in_fat32  = (byte_index >= FAT32_OFS) && (byte_index < FAT32_OFS + FAT32_LEN);
  assign in_tbl    = (byte_index >= TBL_OFS) && (byte_index < SIG_OFS);
  assign m_fat     = (byte_in == fat_char(rel_fat));
  assign m_fat32   = (byte_in == fat_char(rel_fat32));

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index      <= '0;
      fat_match       <= 1'b0;
      fat32_match     <= 1'b0;
      sig_low_byte    <= '0;
      held_sector_lba <= '0;
      held_ext_base   <= '0;
      held_first_num  <= 8'd1;
    end else if (fire) begin
      byte_index <= byte_index + 9'd1;
      if (byte_index == '0) begin
        held_sector_lba <= lba_in;
        held_ext_base   <= base_in;
        held_first_num  <= num_in;
      end
      if (in_fat) begin
        fat_match <= (byte_index == FAT_OFS) ? m_fat : (fat_match && m_fat);
      end
      if (in_fat32) begin
        fat32_match <= (byte_index == FAT32_OFS) ? m_fat32 : (fat32_match && m_fat32);
      end
      if (byte_index == SIG_OFS) begin
        sig_low_byte <= byte_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_tbl) begin
      table_store[rel_tbl] <= byte_in;
    end
    rd_data <= table_store[rd_addr];
  end

  always_comb begin
    info.done       = fire && (byte_index == LAST_IDX);
    info.sig_ok     = (sig_low_byte == SIG_LOW) && (byte_in == SIG_HIGH);
    info.boot_rec   = fat_match || fat32_match;
    info.sector_lba = held_sector_lba;
    info.ext_base   = held_ext_base;
    info.first_num  = held_first_num;
  end

endmodule

// ===== hdl/mbrpt_seq.sv =====
// Result sequencer: walks the four table entries twice through the store read
// port, forms records with one shared 32-bit adder, holds the output item.
// Depends on mbrpt_pkg.

module mbrpt_seq
  import mbrpt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  sector_info_t        info,
  output logic [STORE_AW-1:0] rd_addr,
  input  logic [7:0]          rd_data,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output result_t             res
);

  seq_state_t  state, state_next;
  logic        pass, pass_next;
  logic [1:0]  ent, ent_next;
  logic [3:0]  ofs, ofs_next;
  logic [7:0]  num, num_next;
  kind_t       status_kind, status_next;
  logic [3:0]  prev_ofs;
  logic        pend;
  logic [7:0]  ftype;
  logic [31:0] fstart;
  logic [31:0] flen;

  logic        is_mbr;
  logic        ext;
  logic        part_emit;
  logic        count_it;
  logic        emit;
  logic        slot_free;
  logic        out_load;
  logic [31:0] sum;
  result_t     res_new;

  assign rd_addr   = {ent, ofs};
  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign is_mbr    = (info.sector_lba == '0);
  assign ext       = is_ext_type(ftype);
  assign part_emit = (ftype != '0) && (is_mbr || !ext);
  assign count_it  = is_mbr || ((ftype != '0) && !ext);
  // Shared adder: partition start on the first walk, child sector on the second
  assign sum       = fstart + (pass ? info.ext_base : info.sector_lba);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pass        <= 1'b0;
      ent         <= '0;
      ofs         <= TYPE_OFS;
      num         <= 8'd1;
      status_kind <= KIND_OK;
      pend        <= 1'b0;
    end else begin
      state       <= state_next;
      pass        <= pass_next;
      ent         <= ent_next;
      ofs         <= ofs_next;
      num         <= num_next;
      status_kind <= status_next;
      pend        <= (state == S_FETCH);
    end
  end

  // Collect the byte read from the store in the previous cycle into its field
  always_ff @(posedge clk) begin
    prev_ofs <= ofs;
    if (pend) begin
      if (prev_ofs == TYPE_OFS) begin
        ftype <= rd_data;
      end else if (prev_ofs[3:2] == 2'b10) begin
        fstart[{prev_ofs[1:0], 3'b000} +: 8] <= rd_data;
      end else if (prev_ofs[3:2] == 2'b11) begin
        flen[{prev_ofs[1:0], 3'b000} +: 8] <= rd_data;
      end
    end
  end

  always_comb begin
    state_next  = state;
    pass_next   = pass;
    ent_next    = ent;
    ofs_next    = ofs;
    num_next    = num;
    status_next = status_kind;
    emit        = 1'b0;
    out_load    = 1'b0;
    res_new     = '0;
    unique case (state)
      S_IDLE: begin
        if (info.done) begin
          if (!info.sig_ok) begin
            status_next = KIND_NOSIG;
            state_next  = S_STATUS;
          end else if (info.boot_rec) begin
            status_next = KIND_BOOT;
            state_next  = S_STATUS;
          end else begin
            pass_next  = 1'b0;
            ent_next   = '0;
            ofs_next   = TYPE_OFS;
            num_next   = info.first_num;
            state_next = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        if (ofs == TYPE_OFS) begin
          ofs_next = START_OFS;
        end else if (ofs == (pass ? START_END : LEN_END)) begin
          state_next = S_DRAIN;
        end else begin
          ofs_next = ofs + 4'd1;
        end
      end
      S_DRAIN: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        res_new.part_number = num;
        res_new.start_lba   = sum;
        res_new.sys_ind     = ftype;
        if (!pass) begin
          emit           = part_emit;
          res_new.kind   = KIND_PART;
          res_new.length = flen;
        end else begin
          emit               = ext;
          res_new.kind       = KIND_LINK;
          res_new.child_base = is_mbr ? sum : info.ext_base;
        end
        // Hold here while a record waits for the output slot
        if (!emit || slot_free) begin
          out_load = emit;
          if (!pass && count_it && (num != NUM_MAX)) begin
            num_next = num + 8'd1;
          end
          ofs_next = TYPE_OFS;
          if (ent == 2'd3) begin
            ent_next = '0;
            if (!pass) begin
              pass_next  = 1'b1;
              state_next = S_FETCH;
            end else begin
              status_next = KIND_OK;
              state_next  = S_STATUS;
            end
          end else begin
            ent_next   = ent + 2'd1;
            state_next = S_FETCH;
          end
        end
      end
      S_STATUS: begin
        res_new.kind = status_kind;
        res_new.last = 1'b1;
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res <= res_new;
    end
  end

  a_done_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    info.done |=> (state != S_IDLE))
    else $error("sector end did not start the sequencer");

  a_pend_in_fetch: assert property (@(posedge clk) disable iff (rst)
    pend |-> ((state == S_FETCH) || (state == S_DRAIN)))
    else $error("table read pending outside fetch");

  a_num_frozen_links: assert property (@(posedge clk) disable iff (rst)
    ((state != S_IDLE) && pass) |=> $stable(num))
    else $error("partition number changed during link walk");

  a_last_ends_sector: assert property (@(posedge clk) disable iff (rst)
    (out_load && res_new.last) |=> (state == S_IDLE))
    else $error("final item loaded without returning to idle");

endmodule

// ===== hdl/mbr_ebr_partition_table_parser.sv =====
// Top level of the boot-sector partition table parser: byte capture plus sequencer.
// Depends on mbrpt_pkg, mbrpt_if, mbrpt_capture and mbrpt_seq.
//
// Feed one 512-byte MBR or EBR sector, one byte per item, offsets 0 to 511;
// sector_lba, ext_base and first_part_num are sampled with the byte at offset 0.
// Bytes 0 to 510 are taken one per cycle. After byte 511 the block is not ready
// while it walks the four table entries through the single read port of the
// table store, once for partition records and once for extended links, then
// loads the status item, stalling while an output item waits. Each sector
// yields partition records, then link records for chained EBRs, then one
// status item with last set; a bad signature or a FAT boot record yields only
// that status. The output item is registered, so the next sector's bytes are
// taken while the final status waits.

module mbr_ebr_partition_table_parser
  import mbrpt_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  mbrpt_sector_if.sink  sector,
  mbrpt_result_if.source result
);

  logic                fire;
  logic                in_ready;
  logic [STORE_AW-1:0] rd_addr;
  logic [7:0]          rd_data;
  sector_info_t        info;
  result_t             res;

  assign fire         = sector.valid && in_ready;
  assign sector.ready = in_ready;

  mbrpt_capture u_capture (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .byte_in (sector.sector_byte),
    .lba_in  (sector.sector_lba),
    .base_in (sector.ext_base),
    .num_in  (sector.first_part_num),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .info    (info)
  );

  mbrpt_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .info      (info),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .in_ready  (in_ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .res       (res)
  );

  assign result.kind        = res.kind;
  assign result.part_number = res.part_number;
  assign result.start_lba   = res.start_lba;
  assign result.length      = res.length;
  assign result.sys_ind     = res.sys_ind;
  assign result.child_base  = res.child_base;
  assign result.last        = res.last;

endmodule
